// ----- rtl/tfg_pkg.sv -----
// ----------------------------------------------------------------------------
// Tap / fist gesture classifier package
// Shared widths, register indexes, gesture codes and bundle types.
// ----------------------------------------------------------------------------
package tfg_pkg;

  // Datapath widths.
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 8;

  // Register file geometry.
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_CNT_W  = 8;

  // Magnitude compare width covers both the sample change and thresholds.
  localparam int unsigned MAG_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIST_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIST_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_LOCK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIST_LOCK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SMP_PERIOD  = 3'd7;

  // Gesture codes.
  typedef enum logic [2:0] {
    GEST_NONE      = 3'd0,
    GEST_NEXT_TAP  = 3'd1,
    GEST_PREV_TAP  = 3'd2,
    GEST_NEXT_FIST = 3'd3,
    GEST_PREV_FIST = 3'd4
  } gesture_e;

  // Configuration bundle from the register file to the core.
  typedef struct packed {
    logic [CFG_W-1:0]    tap_low;
    logic [CFG_W-1:0]    fist_low;
    logic [CFG_W-1:0]    fist_high;
    logic [CFG_W-1:0]    tap_lockout_ms;
    logic [CFG_W-1:0]    fist_lockout_ms;
    logic [CFG_W-1:0]    window_ms;
    logic [CFG_W-1:0]    cooldown_ms;
    logic [PERIOD_W-1:0] sample_period_ms;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [2:0]           gesture;
    logic [OUT_CNT_W-1:0] taps_seen;
    logic [OUT_CNT_W-1:0] fists_seen;
  } result_t;

endpackage

// ----- rtl/tfg_if.sv -----
// ----------------------------------------------------------------------------
// Tap / fist gesture classifier channels
// Valid/ready interfaces for the sample channel and the result channel.
// ----------------------------------------------------------------------------
interface tfg_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [tfg_pkg::TIME_BITS-1:0]       time_ms;
  logic signed [tfg_pkg::SAMPLE_BITS-1:0] accel_y;
  logic                                linked;

  modport source (output valid, command, time_ms, accel_y, linked, input ready);
  modport sink   (input valid, command, time_ms, accel_y, linked, output ready);
endinterface

interface tfg_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      gesture;
  logic [tfg_pkg::OUT_CNT_W-1:0]   taps_seen;
  logic [tfg_pkg::OUT_CNT_W-1:0]   fists_seen;

  modport source (output valid, gesture, taps_seen, fists_seen, input ready);
  modport sink   (input valid, gesture, taps_seen, fists_seen, output ready);
endinterface

// ----- rtl/tfg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Tap / fist gesture classifier register file
// Holds the band thresholds and timing registers written over the plain port.
// ----------------------------------------------------------------------------
module tfg_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tfg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tfg_pkg::CFG_W-1:0]       cfg_data_i,
  output tfg_pkg::cfg_t                   cfg_o
);

  tfg_pkg::cfg_t cfg_q;

  // Register writes; each register keeps only its own width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_low          <= 16'd1229;
      cfg_q.fist_low         <= 16'd1638;
      cfg_q.fist_high        <= 16'd3277;
      cfg_q.tap_lockout_ms   <= 16'd180;
      cfg_q.fist_lockout_ms  <= 16'd340;
      cfg_q.window_ms        <= 16'd600;
      cfg_q.cooldown_ms      <= 16'd450;
      cfg_q.sample_period_ms <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tfg_pkg::CFG_TAP_LOW:    cfg_q.tap_low          <= cfg_data_i;
        tfg_pkg::CFG_FIST_LOW:   cfg_q.fist_low         <= cfg_data_i;
        tfg_pkg::CFG_FIST_HIGH:  cfg_q.fist_high        <= cfg_data_i;
        tfg_pkg::CFG_TAP_LOCK:   cfg_q.tap_lockout_ms   <= cfg_data_i;
        tfg_pkg::CFG_FIST_LOCK:  cfg_q.fist_lockout_ms  <= cfg_data_i;
        tfg_pkg::CFG_WINDOW:     cfg_q.window_ms        <= cfg_data_i;
        tfg_pkg::CFG_COOLDOWN:   cfg_q.cooldown_ms      <= cfg_data_i;
        tfg_pkg::CFG_SMP_PERIOD: cfg_q.sample_period_ms <= cfg_data_i[tfg_pkg::PERIOD_W-1:0];
        default:                 cfg_q.tap_low          <= cfg_q.tap_low;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/tfg_core.sv -----
// ----------------------------------------------------------------------------
// Tap / fist gesture classifier core
// Input register, classifier state and the single-pass decision logic.
// ----------------------------------------------------------------------------
module tfg_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tfg_pkg::cfg_t           cfg_i,
  tfg_in_if.sink                  smp_i,
  input  logic                    space_i,
  output logic                    res_valid_o,
  output tfg_pkg::result_t        res_o
);

  localparam int unsigned TW = tfg_pkg::TIME_BITS;
  localparam int unsigned SW = tfg_pkg::SAMPLE_BITS;
  localparam int unsigned CW = tfg_pkg::COUNT_BITS;
  localparam int unsigned MW = tfg_pkg::MAG_W;

  // Input register.
  logic                 in_vld_q;
  logic                 cmd_q, linked_q;
  logic [TW-1:0]        now_q;
  logic signed [SW-1:0] y_q;
  logic                 advance;

  assign advance     = in_vld_q && space_i;
  assign smp_i.ready = !in_vld_q || space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (smp_i.ready) begin
      in_vld_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.ready && smp_i.valid) begin
      cmd_q    <= smp_i.command;
      linked_q <= smp_i.linked;
      now_q    <= smp_i.time_ms;
      y_q      <= smp_i.accel_y;
    end
  end

  // Classifier state.
  logic signed [SW-1:0] prev_y_q, prev_y_d;
  logic [TW-1:0]        last_q, last_d;
  logic [TW-1:0]        lock_end_q, lock_end_d;
  logic [TW-1:0]        win_start_q, win_start_d;
  logic                 win_open_q, win_open_d;
  logic [CW-1:0]        taps_q, taps_d;
  logic [CW-1:0]        fists_q, fists_d;

  // Sample period gate.
  logic [TW-1:0] since_last;
  logic          take, sample;
  assign since_last = now_q - last_q;
  assign take       = since_last >= TW'(cfg_i.sample_period_ms);
  assign sample     = take && cmd_q;

  // Absolute change from the previous accepted sample.
  logic signed [SW:0] diff;
  logic [SW:0]        diff_abs;
  logic [MW-1:0]      mag;
  assign diff     = (SW+1)'(y_q) - (SW+1)'(prev_y_q);
  assign diff_abs = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
  assign mag      = MW'(diff_abs[SW-1:0]);

  // Band classification outside lockout; the fist band takes priority.
  logic unlocked, fist_hit, tap_hit, first_hit;
  assign unlocked = now_q > lock_end_q;
  assign fist_hit = sample && unlocked &&
                    (mag >= MW'(cfg_i.fist_low)) && (mag < MW'(cfg_i.fist_high));
  assign tap_hit  = sample && unlocked && !fist_hit &&
                    (mag >= MW'(cfg_i.tap_low)) && (mag < MW'(cfg_i.fist_low));
  assign first_hit = (fist_hit && (fists_q == '0)) || (tap_hit && (taps_q == '0));

  // Saturating hit counts after this sample.
  logic [CW-1:0] taps_hit, fists_hit;
  assign taps_hit  = (tap_hit && (taps_q != tfg_pkg::COUNT_MAX)) ? taps_q + 1'b1 : taps_q;
  assign fists_hit = (fist_hit && (fists_q != tfg_pkg::COUNT_MAX)) ? fists_q + 1'b1 : fists_q;

  // Window check; a window opened by this sample has elapsed time zero.
  logic [TW-1:0] elapsed;
  logic          open_now, close;
  assign open_now = win_open_q || first_hit;
  assign elapsed  = first_hit ? '0 : (now_q - win_start_q);
  assign close    = open_now && (elapsed > TW'(cfg_i.window_ms));

  // Gesture code from the closed window counts.
  logic [2:0] gesture;
  always_comb begin
    priority if (taps_hit == CW'(1) && fists_hit == '0) begin
      gesture = tfg_pkg::GEST_NEXT_TAP;
    end else if (taps_hit >= CW'(2) && fists_hit == '0) begin
      gesture = tfg_pkg::GEST_PREV_TAP;
    end else if (fists_hit == CW'(1) && taps_hit == '0) begin
      gesture = tfg_pkg::GEST_NEXT_FIST;
    end else if (fists_hit >= CW'(2) && taps_hit == '0) begin
      gesture = tfg_pkg::GEST_PREV_FIST;
    end else begin
      gesture = tfg_pkg::GEST_NONE;
    end
  end

  // Next state for a linked item.
  always_comb begin
    prev_y_d    = prev_y_q;
    last_d      = last_q;
    lock_end_d  = lock_end_q;
    win_start_d = win_start_q;
    win_open_d  = win_open_q;
    taps_d      = taps_q;
    fists_d     = fists_q;
    if (advance && linked_q) begin
      if (take) begin
        last_d = now_q;
      end
      if (sample) begin
        prev_y_d = y_q;
      end
      if (first_hit) begin
        win_start_d = now_q;
      end
      if (fist_hit) begin
        lock_end_d = now_q + TW'(cfg_i.fist_lockout_ms);
      end else if (tap_hit) begin
        lock_end_d = now_q + TW'(cfg_i.tap_lockout_ms);
      end
      if (close) begin
        taps_d     = '0;
        fists_d    = '0;
        win_open_d = 1'b0;
        lock_end_d = now_q + TW'(cfg_i.cooldown_ms);
      end else begin
        taps_d     = taps_hit;
        fists_d    = fists_hit;
        win_open_d = open_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_y_q    <= '0;
      last_q      <= '0;
      lock_end_q  <= '0;
      win_start_q <= '0;
      win_open_q  <= 1'b0;
      taps_q      <= '0;
      fists_q     <= '0;
    end else begin
      prev_y_q    <= prev_y_d;
      last_q      <= last_d;
      lock_end_q  <= lock_end_d;
      win_start_q <= win_start_d;
      win_open_q  <= win_open_d;
      taps_q      <= taps_d;
      fists_q     <= fists_d;
    end
  end

  // Result request toward the output register.
  assign res_valid_o      = advance && linked_q && close;
  assign res_o.gesture    = gesture;
  assign res_o.taps_seen  = tfg_pkg::OUT_CNT_W'(taps_hit);
  assign res_o.fists_seen = tfg_pkg::OUT_CNT_W'(fists_hit);

endmodule

// ----- rtl/tfg_out_reg.sv -----
// ----------------------------------------------------------------------------
// Tap / fist gesture classifier output register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module tfg_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  tfg_pkg::result_t  res_i,
  output logic              space_o,
  tfg_out_if.source         res_o
);

  logic             vld_q;
  tfg_pkg::result_t data_q;

  // The slot is free when empty or when its request leaves this cycle.
  assign space_o = !vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (space_o) begin
      vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid      = vld_q;
  assign res_o.gesture    = data_q.gesture;
  assign res_o.taps_seen  = data_q.taps_seen;
  assign res_o.fists_seen = data_q.fists_seen;

endmodule

// ----- rtl/tap_fist_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// Tap / fist gesture classifier
// Sorts accelerometer Y changes into tap and fist hits and emits gestures.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle on the sample channel, unless
// stalled as below, and works it in a single pass between its input register
// and its output register. Only a linked request that closes a decision window
// produces a result; other linked requests just update the classifier state.
// The rate is set by the single-pass state update in the core; it drops only
// while a finished result waits in the output register and the next request
// has nowhere to go. The user must write registers through the plain
// configuration port only while no request is in flight; the block itself
// does not enforce this.
module tap_fist_gesture_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tfg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tfg_pkg::CFG_W-1:0]      cfg_data_i,
  tfg_in_if.sink                         smp_i,
  tfg_out_if.source                      res_o
);

  tfg_pkg::cfg_t    cfg;
  tfg_pkg::result_t res;
  logic             res_valid;
  logic             space;

  tfg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tfg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .smp_i       (smp_i),
    .space_i     (space),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tfg_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .res_o       (res_o)
  );

endmodule

// ----- rtl/tfg_checker.sv -----
// ----------------------------------------------------------------------------
// Tap / fist gesture classifier checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tfg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [2:0]                     gesture,
  input logic [tfg_pkg::OUT_CNT_W-1:0]  taps_seen,
  input logic [tfg_pkg::OUT_CNT_W-1:0]  fists_seen
);

  // A stalled result request holds its payload.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(gesture) &&
                                $stable(taps_seen) && $stable(fists_seen))
    else $error("result payload changed while stalled");

  // A closed window always holds at least one hit.
  a_res_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (taps_seen != '0) || (fists_seen != '0))
    else $error("result with no hits");

  // A gesture of none is reported only for a mixed window.
  a_res_mixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && gesture == tfg_pkg::GEST_NONE |-> (taps_seen != '0) && (fists_seen != '0))
    else $error("gesture none without a mixed window");

  // Tap gestures match the tap count and carry no fist hits.
  a_res_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (gesture == tfg_pkg::GEST_NEXT_TAP || gesture == tfg_pkg::GEST_PREV_TAP)
    |-> (fists_seen == '0) &&
        ((gesture == tfg_pkg::GEST_NEXT_TAP) == (taps_seen == 8'd1)))
    else $error("tap gesture does not match counts");

  // Fist gestures match the fist count and carry no tap hits.
  a_res_fist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (gesture == tfg_pkg::GEST_NEXT_FIST || gesture == tfg_pkg::GEST_PREV_FIST)
    |-> (taps_seen == '0) &&
        ((gesture == tfg_pkg::GEST_NEXT_FIST) == (fists_seen == 8'd1)))
    else $error("fist gesture does not match counts");

endmodule

bind tap_fist_gesture_classifier tfg_checker u_tfg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .gesture    (res_o.gesture),
  .taps_seen  (res_o.taps_seen),
  .fists_seen (res_o.fists_seen)
);
